// ===== rtl/core/dcte_pkg.sv =====
// Package for the down-counter timecount extender.
// Holds request/response widths, CSR indexes, opcodes and wrap constants.
// No dependencies.
package dcte_pkg;

   // Raw timer and extended count widths
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned COUNT_W = 32;

   // Request tdata: raw_count, tick_pending, pic_pending, cpu_irq_enabled, padding
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;

   // CSR port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_COUNT   = 1'b0,
      REG_EXTEND_MODE = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_READ = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Reset values of the CSRs
   localparam logic [RAW_W-1:0] MAX_COUNT_RESET   = 16'hFFFF;
   localparam logic             EXTEND_MODE_RESET = 1'b1;

   // An elapsed count below this is taken as evidence of a fresh wrap
   localparam logic [COUNT_W-1:0] WRAP_NEAR_ZERO = 32'd20;

   // One request after the input register
   typedef struct packed {
      logic             cpu_irq_enabled;
      logic             pic_pending;
      logic             tick_pending;
      logic [RAW_W-1:0] raw_count;
      opcode_type       opcode;
   } req_type;

endpackage

// ===== rtl/core/down_counter_timecount_extender.sv =====
// Top level of the down-counter timecount extender.
// Input register, single-pass extend logic, result register with state.
// Depends on dcte_pkg.

// Extends a 16-bit down-counting periodic timer into a monotonic 32-bit count.
// A read request (tuser = 0) returns one response with max_count - raw_count
// plus the accumulated period offset in extend mode; a tick request (tuser = 1)
// credits one period unless a read already did and returns nothing. One request
// is taken every cycle unless a read is held up by an untaken response: each
// request is held in the input register, where a single compare-and-add against
// the offset state decides its result, and a read then waits in the response
// register until taken. CSR writes are taken at once and must only be issued
// while the block is idle.
module down_counter_timecount_extender
   import dcte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: raw_count[15:0], tick_pending[16], pic_pending[17],
   //        cpu_irq_enabled[18], zero[23:19]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: opcode (0 read, 1 tick)
   input  logic                   req_tuser,
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: timecount[31:0]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // CSR write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // CSRs
   logic [RAW_W-1:0]   max_count_ff;
   logic               extend_mode_ff;

   // Input register
   logic               req_valid_ff;
   req_type            req_ff;

   // Extension state
   logic [COUNT_W-1:0] last_elapsed_ff, last_elapsed_in;
   logic [COUNT_W-1:0] period_offset_ff, period_offset_in;
   logic               wrap_credited_ff, wrap_credited_in;

   // Response register
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] timecount_ff, timecount_in;

   logic               advance;
   logic               is_tick;
   logic [COUNT_W-1:0] max_wide;
   logic [COUNT_W-1:0] elapsed;
   logic               evident;
   logic               credit;
   logic [COUNT_W-1:0] offset_add;

   assign csr_ready = 1'b1;

   // Move the held request on when it has no response or the response slot frees up
   assign is_tick    = (req_ff.opcode == OP_TICK);
   assign advance    = req_valid_ff && (is_tick || !rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign max_wide = {{(COUNT_W-RAW_W){1'b0}}, max_count_ff};
   assign elapsed  = max_wide - {{(COUNT_W-RAW_W){1'b0}}, req_ff.raw_count};

   // Wrap evidence and the decision to credit a period
   always_comb begin
      evident = (elapsed < WRAP_NEAR_ZERO) ||
                (!req_ff.cpu_irq_enabled && (elapsed < (max_wide >> 1)));
      credit  = 1'b0;
      if (is_tick) begin
         credit = !wrap_credited_ff;
      end else begin
         credit = (elapsed < last_elapsed_ff) ||
                  (!wrap_credited_ff &&
                   (req_ff.tick_pending || (evident && req_ff.pic_pending)));
      end
      offset_add = credit ? max_wide : '0;
   end

   // Next state and response value
   always_comb begin
      last_elapsed_in  = last_elapsed_ff;
      period_offset_in = period_offset_ff;
      wrap_credited_in = wrap_credited_ff;
      timecount_in     = elapsed;
      if (advance && extend_mode_ff) begin
         period_offset_in = period_offset_ff + offset_add;
         if (is_tick) begin
            wrap_credited_in = 1'b0;
            if (credit) begin
               last_elapsed_in = '0;
            end
         end else begin
            last_elapsed_in = elapsed;
            if (credit) begin
               wrap_credited_in = 1'b1;
            end
         end
      end
      if (extend_mode_ff) begin
         timecount_in = elapsed + period_offset_in;
      end
   end

   // Hold CSRs, input register, state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff     <= MAX_COUNT_RESET;
         extend_mode_ff   <= EXTEND_MODE_RESET;
         req_valid_ff     <= 1'b0;
         last_elapsed_ff  <= '0;
         period_offset_ff <= '0;
         wrap_credited_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_COUNT:   max_count_ff   <= csr_data[RAW_W-1:0];
               REG_EXTEND_MODE: extend_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         last_elapsed_ff  <= last_elapsed_in;
         period_offset_ff <= period_offset_in;
         wrap_credited_ff <= wrap_credited_in;
         if (advance && !is_tick) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.raw_count       <= req_tdata[RAW_W-1:0];
         req_ff.tick_pending    <= req_tdata[RAW_W];
         req_ff.pic_pending     <= req_tdata[RAW_W+1];
         req_ff.cpu_irq_enabled <= req_tdata[RAW_W+2];
         req_ff.opcode          <= opcode_type'(req_tuser);
      end
      if (advance && !is_tick) begin
         timecount_ff <= timecount_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = timecount_ff;

   // Offset state only moves when a request is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(period_offset_ff) && $stable(last_elapsed_ff))
      else $error("extension state changed with no request processed");

   // Simple mode leaves the extension state alone
   a_simple_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && !extend_mode_ff) |=> $stable(period_offset_ff) &&
         $stable(wrap_credited_ff))
      else $error("state changed in simple mode");

   // A tick in extend mode always clears the wrap mark
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_tick && extend_mode_ff) |=> !wrap_credited_ff)
      else $error("tick left wrap mark set");

   // A response appears only from a processed read
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) && !(advance && !is_tick) |=> !rsp_valid_ff)
      else $error("response produced without a read");

   // A held response is never overwritten before it is taken
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(advance && !is_tick))
      else $error("response overwritten while stalled");

endmodule
